>>> hdl/chained_hash_table_engine_defines.svh
// assertion macros for the chained hash table engine
// no dependencies; the enclosing module must have clk and rst_n
`ifndef CHAINED_HASH_TABLE_ENGINE_DEFINES_SVH
`define CHAINED_HASH_TABLE_ENGINE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CHTE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define CHTE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/chte_pkg.sv
// shared types and constants of the chained hash table engine
// no dependencies
package chte_pkg;

    // fixed field widths of the request and response channels
    localparam int OPCODE_W = 3;
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_LOOKUP = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_SET    = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_ERASE  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic scan;
        logic act;
        logic shift;
        logic sweep;
        logic load_out;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic scan_done;
        logic shift_done;
        logic sweep_last;
        logic found;
        logic op_erase;
        logic op_clear;
        logic out_free;
    } stat_t;

endpackage

>>> hdl/chte_if.sv
// request and response channel interfaces of the chained hash table engine
// depends on chte_pkg
interface chte_req_if import chte_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [KEY_W-1:0]    key;
    logic [VALUE_W-1:0]  value;

    modport source (output valid, output opcode, output key, output value, input ready);
    modport sink   (input valid, input opcode, input key, input value, output ready);
endinterface

interface chte_rsp_if import chte_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                hit;
    logic [VALUE_W-1:0]  value_out;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, output hit, output value_out, output status,
                    output entry_count, input ready);
    modport sink   (input valid, input hit, input value_out, input status,
                    input entry_count, output ready);
endinterface

>>> hdl/chte_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module chte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port, holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/chte_ctrl.sv
// controller state machine of the chained hash table engine
// depends on chte_pkg
module chte_ctrl import chte_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [2:0] S_SWEEP = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_ACT   = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       sweep_resp_reg;
    logic       sweep_resp_next;

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        sweep_resp_next = sweep_resp_reg;
        cmd             = '0;
        in_ready        = 1'b0;
        case (state_reg)
            S_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next      = sweep_resp_reg ? S_DONE : S_IDLE;
                    sweep_resp_next = 1'b0;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_ACT;
                end
            end
            S_ACT:
            begin
                cmd.act = 1'b1;
                if (stat.op_clear)
                begin
                    sweep_resp_next = 1'b1;
                    state_next      = S_SWEEP;
                end
                else if (stat.op_erase && stat.found)
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (stat.shift_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers, reset starts the fill clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            sweep_resp_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_resp_reg <= sweep_resp_next;
        end
    end

endmodule

>>> hdl/chte_datapath.sv
// datapath of the chained hash table engine: slot and fill memories, scan and shift
// depends on chte_pkg, chte_ram and chained_hash_table_engine_defines.svh
`include "chained_hash_table_engine_defines.svh"

module chte_datapath import chte_pkg::*; #(
    parameter int NUM_BUCKETS  = 64,
    parameter int BUCKET_DEPTH = 4,
    parameter int KEY_BITS     = 32,
    parameter int VALUE_BITS   = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output stat_t               stat,
    input  logic [OPCODE_W-1:0] in_opcode,
    input  logic [KEY_W-1:0]    in_key,
    input  logic [VALUE_W-1:0]  in_value,
    input  logic                out_ready,
    output logic                out_valid,
    output logic                out_hit,
    output logic [VALUE_W-1:0]  out_value,
    output logic [STATUS_W-1:0] out_status,
    output logic [COUNT_W-1:0]  out_count
);

    localparam int SLOTS = NUM_BUCKETS * BUCKET_DEPTH;
    localparam int KW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int VW    = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam int SW    = KW + VW;
    localparam int BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int SAW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IW    = $clog2(BUCKET_DEPTH + 1);
    localparam int TW    = $clog2(SLOTS + 1);

    // request payload
    logic [OPCODE_W-1:0] op_reg;
    logic [KW-1:0]       key_reg;
    logic [VW-1:0]       val_reg;
    logic [BW-1:0]       bucket_reg;
    logic [SAW-1:0]      base_reg;

    // scan and shift state
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] rd_idx_reg;
    logic          pend_reg;
    logic          found_reg;
    logic [VW-1:0] found_val_reg;
    logic [TW-1:0] total_reg;
    logic [BW-1:0] sweep_cnt_reg;

    // result and output registers
    logic                res_hit_reg;
    logic [VW-1:0]       res_val_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                res_hit_next;
    logic [VW-1:0]       res_val_next;
    logic [STATUS_W-1:0] res_status_next;
    logic                out_valid_reg;
    logic                out_hit_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [COUNT_W-1:0]  out_count_reg;

    // memory ports
    logic           fill_we;
    logic [BW-1:0]  fill_waddr;
    logic [IW-1:0]  fill_wdata;
    logic [IW-1:0]  fill;
    logic           slot_re;
    logic [SAW-1:0] slot_raddr;
    logic [SW-1:0]  slot_rdata;
    logic           slot_we;
    logic [SAW-1:0] slot_waddr;
    logic [SW-1:0]  slot_wdata;

    // internal decode
    logic [KW-1:0]         key_m;
    logic [BW+KW-1:0]      key_x;
    logic [BW-1:0]         in_bucket;
    logic [SAW-1:0]        in_base;
    logic [KW-1:0]         rd_key;
    logic [VW-1:0]         rd_val;
    logic                  cmp_hit;
    logic                  scan_more;
    logic                  scan_done;
    logic                  full;
    logic [IW-1:0]         nxt_idx;
    logic [IW-1:0]         prev_idx;
    logic                  shift_more;
    logic                  is_store;
    logic                  ins_new;
    logic [TW+COUNT_W-1:0] total_x;

    // key masking and bucket select from the low key bits
    assign key_m     = in_key[KW-1:0];
    assign key_x     = {{BW{1'b0}}, key_m};
    assign in_bucket = (NUM_BUCKETS > 1) ? key_x[BW-1:0] : '0;
    assign in_base   = SAW'(in_bucket) * SAW'(BUCKET_DEPTH);

    // slot compare and loop conditions
    assign rd_key     = slot_rdata[SW-1:VW];
    assign rd_val     = slot_rdata[VW-1:0];
    assign cmp_hit    = pend_reg && (rd_key == key_reg);
    assign scan_more  = idx_reg < fill;
    assign scan_done  = cmp_hit || !scan_more;
    assign full       = fill >= IW'(BUCKET_DEPTH);
    assign nxt_idx    = IW'(rd_idx_reg + 1'b1);
    assign prev_idx   = IW'(rd_idx_reg - 1'b1);
    assign shift_more = nxt_idx < fill;
    assign is_store   = (op_reg == OP_INSERT) || (op_reg == OP_SET);
    assign ins_new    = is_store && !found_reg && !full;

    // status to the controller
    assign stat.scan_done  = scan_done;
    assign stat.shift_done = !shift_more;
    assign stat.sweep_last = sweep_cnt_reg == BW'(NUM_BUCKETS - 1);
    assign stat.found      = found_reg;
    assign stat.op_erase   = op_reg == OP_ERASE;
    assign stat.op_clear   = op_reg == OP_CLEAR;
    assign stat.out_free   = !out_valid_reg || out_ready;

    // fill memory write select: clearing sweep, insert, erase
    always_comb
    begin
        fill_we    = 1'b0;
        fill_waddr = bucket_reg;
        fill_wdata = IW'(fill + 1'b1);
        if (cmd.sweep)
        begin
            fill_we    = 1'b1;
            fill_waddr = sweep_cnt_reg;
            fill_wdata = '0;
        end
        else if (cmd.act && ins_new)
        begin
            fill_we = 1'b1;
        end
        else if (cmd.shift && !shift_more)
        begin
            fill_we    = 1'b1;
            fill_wdata = IW'(fill - 1'b1);
        end
    end

    // slot memory read during scan and shift
    assign slot_re    = (cmd.scan && !scan_done) || (cmd.shift && shift_more);
    assign slot_raddr = base_reg + SAW'(cmd.shift ? nxt_idx : idx_reg);

    // slot memory write: append, overwrite in place, shift down
    always_comb
    begin
        slot_we    = 1'b0;
        slot_waddr = base_reg + SAW'(fill);
        slot_wdata = {key_reg, val_reg};
        if (cmd.act && ins_new)
        begin
            slot_we = 1'b1;
        end
        else if (cmd.act && (op_reg == OP_SET) && found_reg)
        begin
            slot_we    = 1'b1;
            slot_waddr = base_reg + SAW'(rd_idx_reg);
        end
        else if (cmd.shift && pend_reg)
        begin
            slot_we    = 1'b1;
            slot_waddr = base_reg + SAW'(prev_idx);
            slot_wdata = slot_rdata;
        end
    end

    // result of the operation
    always_comb
    begin
        res_hit_next    = found_reg;
        res_val_next    = '0;
        res_status_next = ST_OK;
        case (op_reg)
            OP_LOOKUP:
            begin
                if (found_reg)
                begin
                    res_val_next = found_val_reg;
                end
                else
                begin
                    res_status_next = ST_MISSING;
                end
            end
            OP_INSERT:
            begin
                if (found_reg)
                begin
                    res_status_next = ST_PRESENT;
                end
                else if (full)
                begin
                    res_status_next = ST_FULL;
                end
            end
            OP_SET:
            begin
                if (!found_reg && full)
                begin
                    res_status_next = ST_FULL;
                end
            end
            OP_ERASE:
            begin
                if (!found_reg)
                begin
                    res_status_next = ST_MISSING;
                end
            end
            default:
            begin
                res_hit_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            total_reg     <= '0;
            sweep_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // new request
            if (cmd.accept)
            begin
                idx_reg   <= '0;
                pend_reg  <= 1'b0;
                found_reg <= 1'b0;
            end
            // scan: read the next slot while comparing the previous one
            if (cmd.scan)
            begin
                if (cmp_hit)
                begin
                    found_reg <= 1'b1;
                end
                if (scan_done)
                begin
                    pend_reg <= 1'b0;
                end
                else
                begin
                    pend_reg   <= 1'b1;
                    rd_idx_reg <= idx_reg;
                    idx_reg    <= IW'(idx_reg + 1'b1);
                end
            end
            // shift down the entries after the erased one
            if (cmd.shift)
            begin
                if (shift_more)
                begin
                    pend_reg   <= 1'b1;
                    rd_idx_reg <= nxt_idx;
                end
                else
                begin
                    pend_reg <= 1'b0;
                end
            end
            // entry count
            if (cmd.act && ins_new)
            begin
                total_reg <= TW'(total_reg + 1'b1);
            end
            else if (cmd.act && (op_reg == OP_CLEAR))
            begin
                total_reg <= '0;
            end
            else if (cmd.shift && !shift_more)
            begin
                total_reg <= TW'(total_reg - 1'b1);
            end
            // fill clearing sweep
            if (cmd.sweep)
            begin
                sweep_cnt_reg <= stat.sweep_last ? '0 : BW'(sweep_cnt_reg + 1'b1);
            end
            // output handshake
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign total_x = {{COUNT_W{1'b0}}, total_reg};

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg     <= in_opcode;
            key_reg    <= key_m;
            val_reg    <= in_value[VW-1:0];
            bucket_reg <= in_bucket;
            base_reg   <= in_base;
        end
        if (cmd.scan && cmp_hit)
        begin
            found_val_reg <= rd_val;
        end
        if (cmd.act)
        begin
            res_hit_reg    <= res_hit_next;
            res_val_reg    <= res_val_next;
            res_status_reg <= res_status_next;
        end
        if (cmd.load_out)
        begin
            out_hit_reg    <= res_hit_reg;
            out_value_reg  <= VALUE_W'(res_val_reg);
            out_status_reg <= res_status_reg;
            out_count_reg  <= total_x[COUNT_W-1:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_hit    = out_hit_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;
    assign out_count  = out_count_reg;

    // bucket fill counts, one word per bucket
    chte_ram #(
        .WIDTH (IW),
        .DEPTH (NUM_BUCKETS)
    ) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (fill_waddr),
        .wdata (fill_wdata),
        .re    (cmd.accept),
        .raddr (in_bucket),
        .rdata (fill)
    );

    // key and value slots, bucket-major
    chte_ram #(
        .WIDTH (SW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    // checks
    `CHTE_ASSERT_IMP(a_total_bound, 1'b1, total_reg <= TW'(SLOTS), "entry count above capacity")
    `CHTE_ASSERT_IMP(a_sweep_empty, cmd.sweep, total_reg == '0, "fill sweep with entries held")
    `CHTE_ASSERT_IMP(a_hit_in_fill, cmd.act && found_reg, rd_idx_reg < fill, "hit beyond fill")
    `CHTE_ASSERT_NXT(a_insert_count, cmd.act && ins_new, total_reg == $past(total_reg) + 1'b1,
        "insert did not count")

endmodule

>>> hdl/chained_hash_table_engine.sv
// top level of the chained hash table engine
// depends on chte_pkg, chte_if, chte_ctrl, chte_datapath
//
//  channel  dir  handshake    payload
//  req      in   valid/ready  opcode[2:0] key[31:0] value[31:0]
//  rsp      out  valid/ready  hit value_out[31:0] status[1:0] entry_count[8:0]
//
// one request at a time: accept, scan of the bucket up to a hit or its fill (slot ram
// port), act, then response load; an erase hit adds a shift of the later entries down
// and a clear adds a sweep to zero the fill ram
// after reset a sweep clears the fill ram bucket by bucket; req.ready is low
// a response held by rsp.ready stalls the next response, and with it request accept
module chained_hash_table_engine import chte_pkg::*; #(
    parameter int NUM_BUCKETS  = 64,
    parameter int BUCKET_DEPTH = 4,
    parameter int KEY_BITS     = 32,
    parameter int VALUE_BITS   = 32
) (
    input logic      clk,
    input logic      rst_n,
    chte_req_if.sink req,
    chte_rsp_if.source rsp
);

    cmd_t  cmd;
    stat_t stat;
    logic  in_ready;

    // controller
    chte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    assign req.ready = in_ready;

    // datapath
    chte_datapath #(
        .NUM_BUCKETS  (NUM_BUCKETS),
        .BUCKET_DEPTH (BUCKET_DEPTH),
        .KEY_BITS     (KEY_BITS),
        .VALUE_BITS   (VALUE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_opcode  (req.opcode),
        .in_key     (req.key),
        .in_value   (req.value),
        .out_ready  (rsp.ready),
        .out_valid  (rsp.valid),
        .out_hit    (rsp.hit),
        .out_value  (rsp.value_out),
        .out_status (rsp.status),
        .out_count  (rsp.entry_count)
    );

endmodule

>>> test/tb_chained_hash_table_engine.sv
`timescale 1ns / 100ps
// self-checking testbench for chained_hash_table_engine: directed and random requests
// depends on chte_pkg, chte_if (chte_req_if, chte_rsp_if) and the engine rtl
module tb_chained_hash_table_engine;
    import chte_pkg::*;

    localparam int NB          = 64;
    localparam int DEPTH       = 4;
    localparam int POOL        = 24;
    localparam int SETTLE      = NB + 16;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int MAX_REPORTS = 30;

    // opcodes with no operation
    localparam logic [OPCODE_W-1:0] OP_RSVD5 = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_RSVD7 = 3'd7;

    typedef struct packed {
        logic                hit;
        logic [VALUE_W-1:0]  value_out;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  entry_count;
    } hash_rsp_t;

    // shadow copy of the table plus the queue of responses it predicts
    class hash_table_scoreboard;
        logic [KEY_W-1:0]   slot_key [NB][DEPTH];
        logic [VALUE_W-1:0] slot_val [NB][DEPTH];
        int unsigned        fill [NB];
        int unsigned        total;
        hash_rsp_t          awaited [$];
        int unsigned        errors;
        int unsigned        checked;
        int unsigned        status_seen [4];

        function void note_request(logic [OPCODE_W-1:0] op, logic [KEY_W-1:0] key,
                                   logic [VALUE_W-1:0] val);
            int unsigned b;
            int unsigned n;
            int unsigned pos;
            int unsigned i;
            bit          present;
            hash_rsp_t   r;
            b   = key % NB;
            n   = fill[b];
            pos = n;
            // first matching slot within the bucket fill
            for (i = 0; i < n; i++)
            begin
                if (pos == n && slot_key[b][i] == key)
                    pos = i;
            end
            present = (pos < n);
            r = '0;
            case (op)
                OP_LOOKUP:
                begin
                    r.hit = present;
                    if (present)
                        r.value_out = slot_val[b][pos];
                    else
                        r.status = ST_MISSING;
                end
                OP_INSERT, OP_SET:
                begin
                    r.hit = present;
                    if (present)
                    begin
                        if (op == OP_INSERT)
                            r.status = ST_PRESENT;
                        else
                            slot_val[b][pos] = val;
                    end
                    else if (n >= DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        slot_key[b][n] = key;
                        slot_val[b][n] = val;
                        fill[b] = n + 1;
                        total++;
                    end
                end
                OP_ERASE:
                begin
                    r.hit = present;
                    if (present)
                    begin
                        // later entries move down one slot, order kept
                        for (i = pos + 1; i < n; i++)
                        begin
                            slot_key[b][i-1] = slot_key[b][i];
                            slot_val[b][i-1] = slot_val[b][i];
                        end
                        fill[b] = n - 1;
                        total--;
                    end
                    else
                        r.status = ST_MISSING;
                end
                OP_CLEAR:
                begin
                    for (i = 0; i < NB; i++)
                        fill[i] = 0;
                    total = 0;
                end
                default:
                    ;
            endcase
            r.entry_count = total[COUNT_W-1:0];
            awaited.push_back(r);
        endfunction

        function void check_response(hash_rsp_t got);
            hash_rsp_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected response hit=%0d value=%h status=%0d count=%0d",
                             $time, got.hit, got.value_out, got.status, got.entry_count);
                return;
            end
            want = awaited.pop_front();
            checked++;
            status_seen[want.status]++;
            if (got !== want)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $display("%0t: mismatch, expected hit=%0d value=%h status=%0d count=%0d",
                             $time, want.hit, want.value_out, want.status, want.entry_count);
                    $display("%0t: mismatch, actual   hit=%0d value=%h status=%0d count=%0d",
                             $time, got.hit, got.value_out, got.status, got.entry_count);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int unsigned cycle_count;
    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    logic [KEY_W-1:0] key_pool [POOL];
    hash_table_scoreboard shadow = new();

    chte_req_if req_ch();
    chte_rsp_if rsp_ch();

    chained_hash_table_engine #(
        .NUM_BUCKETS  (NB),
        .BUCKET_DEPTH (DEPTH),
        .KEY_BITS     (KEY_W),
        .VALUE_BITS   (VALUE_W)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // response side: random stalls set at the falling edge
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready = ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // accepted request: predict its response
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
            shadow.note_request(req_ch.opcode, req_ch.key, req_ch.value);
    end

    // accepted response: compare with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            shadow.check_response(hash_rsp_t'{rsp_ch.hit, rsp_ch.value_out,
                                              rsp_ch.status, rsp_ch.entry_count});
    end

    task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [KEY_W-1:0] key,
                                input logic [VALUE_W-1:0] val);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            @(negedge clk);
            req_ch.valid = 1'b0;
        end
        @(negedge clk);
        req_ch.valid  = 1'b1;
        req_ch.opcode = op;
        req_ch.key    = key;
        req_ch.value  = val;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // hold off the sender until every predicted response has come back
    task automatic drain_responses();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (shadow.awaited.size() != 0)
            @(posedge clk);
    endtask

    // keys clustered on a few neighboring buckets so buckets fill up
    function automatic void refill_pool();
        int unsigned base;
        logic [KEY_W-1:0] k;
        base = $urandom_range(0, NB - 6);
        for (int i = 0; i < POOL; i++)
        begin
            k = $urandom();
            k[5:0] = 6'(base + $urandom_range(0, 5));
            key_pool[i] = k;
        end
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        return key_pool[$urandom_range(0, POOL - 1)];
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom();
    endfunction

    task automatic run_random(input int count);
        int unsigned r;
        logic [OPCODE_W-1:0] op;
        for (int n = 0; n < count; n++)
        begin
            if (n % 150 == 0)
                refill_pool();
            r = $urandom_range(0, 99);
            if (r < 28)
                op = OP_LOOKUP;
            else if (r < 55)
                op = OP_INSERT;
            else if (r < 70)
                op = OP_SET;
            else if (r < 90)
                op = OP_ERASE;
            else if (r < 92)
                op = OP_CLEAR;
            else
                op = OPCODE_W'($urandom_range(OP_RSVD5, OP_RSVD7));
            send_request(op, pick_key(), pick_value());
        end
    endtask

    // fill every bucket to depth, overflow one, look up random keys, then clear
    task automatic run_fill_all();
        logic [KEY_W-1:0] k;
        for (int b = 0; b < NB; b++)
        begin
            for (int d = 0; d < DEPTH; d++)
            begin
                k = $urandom();
                k[5:0] = 6'(b);
                send_request(OP_INSERT, k, pick_value());
            end
        end
        k = $urandom();
        send_request(OP_INSERT, k, pick_value());
        for (int n = 0; n < 8; n++)
        begin
            k = $urandom();
            send_request(OP_LOOKUP, k, '0);
        end
        send_request(OP_CLEAR, $urandom(), $urandom());
    endtask

    initial
    begin
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.opcode  = OP_LOOKUP;
        req_ch.key     = '0;
        req_ch.value   = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: misses, duplicates, overwrite, full bucket, erase with shift, reserved opcodes, clear
        send_request(OP_LOOKUP, 32'h0000_0000, 32'h0);
        send_request(OP_ERASE,  32'h0000_0000, 32'h0);
        send_request(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 32'h0000_0000, 32'h0000_0001);
        send_request(OP_LOOKUP, 32'h0000_0000, 32'h0);
        send_request(OP_SET,    32'h0000_0000, 32'h0000_0000);
        send_request(OP_LOOKUP, 32'h0000_0000, 32'h0);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(OP_INSERT, 32'h0000_0040, 32'hA5A5_A5A5);
        send_request(OP_INSERT, 32'h0000_0080, 32'h5A5A_5A5A);
        send_request(OP_SET,    32'h0000_00C0, 32'h1234_5678);
        send_request(OP_INSERT, 32'h0000_0100, 32'h0BAD_F00D);
        send_request(OP_SET,    32'h0000_0140, 32'h0000_0002);
        send_request(OP_ERASE,  32'h0000_0040, 32'h0);
        send_request(OP_LOOKUP, 32'h0000_0080, 32'h0);
        send_request(OP_LOOKUP, 32'h0000_00C0, 32'h0);
        send_request(OP_LOOKUP, 32'h0000_0040, 32'h0);
        send_request(OP_INSERT, 32'h0000_0100, 32'h8000_0001);
        send_request(OP_ERASE,  32'h0000_0000, 32'h0);
        send_request(OP_ERASE,  32'h0000_0100, 32'h0);
        send_request(OP_RSVD5,  $urandom(), $urandom());
        send_request(OP_RSVD6,  $urandom(), $urandom());
        send_request(OP_RSVD7,  $urandom(), $urandom());
        send_request(OP_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        drain_responses();

        // whole table full, entry count at its top
        run_fill_all();
        drain_responses();

        // random mixes under different throttling
        src_idle_pct = 0;  sink_stall_pct = 0;
        run_random(410);
        drain_responses();
        src_idle_pct = 56; sink_stall_pct = 0;
        run_random(410);
        drain_responses();
        src_idle_pct = 0;  sink_stall_pct = 56;
        run_random(410);
        drain_responses();
        src_idle_pct = 9;  sink_stall_pct = 9;
        run_random(410);
        drain_responses();
        repeat (SETTLE) @(posedge clk);

        $display("run checked %0d responses: directed cases, a full-table fill, four stall mixes",
                 shadow.checked);
        $display("statuses seen: ok %0d, already present %0d, not found %0d, bucket full %0d",
                 shadow.status_seen[ST_OK], shadow.status_seen[ST_PRESENT],
                 shadow.status_seen[ST_MISSING], shadow.status_seen[ST_FULL]);
        if (shadow.errors == 0 && shadow.awaited.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

>>> files.f
+incdir+hdl
hdl/chte_pkg.sv
hdl/chte_if.sv
hdl/chte_ram.sv
hdl/chte_ctrl.sv
hdl/chte_datapath.sv
hdl/chained_hash_table_engine.sv
test/tb_chained_hash_table_engine.sv
